// File: rtl/gpja_pkg.sv
// ----------------------------------------------------------------------------
// gpja_pkg
// Shared widths, constants, codes and helper functions for the gaze point
// to joint angle pipeline.
// ----------------------------------------------------------------------------
package gpja_pkg;

  // field widths
  localparam int W_IN      = 21;
  localparam int W_OFF     = 18;
  localparam int W_HB      = 17;
  localparam int W_ANG     = 19;
  localparam int W_CFG_IDX = 2;

  // internal datapath widths
  localparam int W_N2     = 42;           // |p|^2 and x^2+z^2
  localparam int W_YYO    = W_IN + W_OFF; // y * lateral offset
  localparam int W_MUL    = 44;           // multiplier operand
  localparam int W_SQ_OUT = 44;           // square root result
  localparam int W_SQ_IN  = 2 * W_SQ_OUT; // square root radicand
  localparam int W_OP     = 46;           // atan2 operand
  localparam int W_C      = 33;           // q30 angle and cordic datapath

  // angle formats
  localparam int ANG_Q     = 30;
  localparam int FRAC_BITS = 16;
  localparam int ANG_SHIFT = ANG_Q - FRAC_BITS;
  localparam logic signed [W_C-1:0] PI_Q30      = 33'sd3373259426;
  localparam logic signed [W_C-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic [W_C:0] RND_HALF = (W_C+1)'(1) << (ANG_SHIFT - 1);

  localparam int CORDIC_STEPS = 30;

  // unit latencies
  localparam int MUL_LAT    = 3;
  localparam int SQRT_LAT   = W_SQ_OUT;
  localparam int CORDIC_LAT = 4 + CORDIC_STEPS + 1;

  localparam logic [W_HB-1:0] HB_RESET = 17'd3277;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_INSIDE = 2'd2
  } status_t;

  typedef enum logic [W_CFG_IDX-1:0] {
    CFG_LATERAL  = 2'd0,
    CFG_VERTICAL = 2'd1,
    CFG_HALFBASE = 2'd2
  } cfg_idx_t;

  // flags that ride along the cordic stages
  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } cside_t;

  function automatic logic signed [W_C-1:0] atan_q30(input int i);
    logic signed [W_C-1:0] a;
    case (i)
      0:       a = 33'sd843314857;
      1:       a = 33'sd497837829;
      2:       a = 33'sd263043837;
      3:       a = 33'sd133525159;
      4:       a = 33'sd67021687;
      5:       a = 33'sd33543516;
      6:       a = 33'sd16775851;
      7:       a = 33'sd8388437;
      8:       a = 33'sd4194283;
      9:       a = 33'sd2097149;
      default: a = W_C'(1) <<< (ANG_Q - i);
    endcase
    return a;
  endfunction

  // q30 radians to output units, round half away from zero
  function automatic logic [W_ANG-1:0] to_out(input logic signed [W_C-1:0] a);
    logic [W_C:0] ext;
    logic [W_C:0] mg;
    logic [W_C:0] rs;
    ext = (W_C+1)'(a);
    mg  = a[W_C-1] ? (~ext + (W_C+1)'(1)) : ext;
    rs  = (mg + RND_HALF) >> ANG_SHIFT;
    return a[W_C-1] ? W_ANG'(~rs + (W_C+1)'(1)) : W_ANG'(rs);
  endfunction

endpackage

// File: rtl/gpja_mul.sv
// ----------------------------------------------------------------------------
// gpja_mul
// Pipelined unsigned multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module gpja_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic [gpja_pkg::W_MUL-1:0]     a,
  input  logic [gpja_pkg::W_MUL-1:0]     b,
  output logic                           out_vld,
  output logic [2*gpja_pkg::W_MUL-1:0]   prod
);
  import gpja_pkg::*;

  localparam int H = W_MUL / 2;

  logic [2*H-1:0]     p00_r, p01_r, p10_r, p11_r;
  logic [2*W_MUL-1:0] base_r, prod_r;
  logic [2*H:0]       mid_r;
  logic [MUL_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    p00_r  <= (2*H)'(a[H-1:0])     * (2*H)'(b[H-1:0]);
    p01_r  <= (2*H)'(a[H-1:0])     * (2*H)'(b[W_MUL-1:H]);
    p10_r  <= (2*H)'(a[W_MUL-1:H]) * (2*H)'(b[H-1:0]);
    p11_r  <= (2*H)'(a[W_MUL-1:H]) * (2*H)'(b[W_MUL-1:H]);
    base_r <= {p11_r, p00_r};
    mid_r  <= {1'b0, p01_r} + {1'b0, p10_r};
    prod_r <= base_r + ((2*W_MUL)'(mid_r) << H);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[MUL_LAT-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[MUL_LAT-1];
  assign prod    = prod_r;

endmodule

// File: rtl/gpja_isqrt.sv
// ----------------------------------------------------------------------------
// gpja_isqrt
// Pipelined integer square root, rounded down, one root bit per stage.
// ----------------------------------------------------------------------------
module gpja_isqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic [gpja_pkg::W_SQ_IN-1:0]    val,
  output logic                            out_vld,
  output logic [gpja_pkg::W_SQ_OUT-1:0]   root
);
  import gpja_pkg::*;

  logic [W_SQ_IN-1:0]  rem_r  [W_SQ_OUT-1];
  logic [W_SQ_OUT-1:0] root_r [W_SQ_OUT];
  logic [W_SQ_OUT-1:0] vld_r;

  for (genvar k = 0; k < W_SQ_OUT; k++) begin : g_bit
    localparam int B = W_SQ_OUT - 1 - k;
    logic [W_SQ_IN-1:0]  rem_in;
    logic [W_SQ_IN-1:0]  trial;
    logic [W_SQ_OUT-1:0] root_in;
    logic                take;

    if (k == 0) begin : g_first
      assign rem_in  = val;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (root + 2^b)^2 - root^2, the root bits sit above b so or is enough
    assign trial = (W_SQ_IN'(root_in) << (B + 1)) | (W_SQ_IN'(1) << (2 * B));
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      root_r[k] <= take ? (root_in | (W_SQ_OUT'(1) << B)) : root_in;
    end

    if (k < W_SQ_OUT - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k] <= take ? (rem_in - trial) : rem_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[W_SQ_OUT-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[W_SQ_OUT-1];
  assign root    = root_r[W_SQ_OUT-1];

endmodule

// File: rtl/gpja_cordic.sv
// ----------------------------------------------------------------------------
// gpja_cordic
// Pipelined atan2 in q30: magnitude and normalize over four stages, one
// vectoring step per stage, then clamp and quadrant mapping.
// ----------------------------------------------------------------------------
module gpja_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [gpja_pkg::W_OP-1:0]  op_y,
  input  logic signed [gpja_pkg::W_OP-1:0]  op_x,
  output logic                              out_vld,
  output logic signed [gpja_pkg::W_C-1:0]   angle
);
  import gpja_pkg::*;

  localparam int NG       = (W_OP + 7) / 8;
  localparam int W_POS    = $clog2(NG * 8);
  localparam int NORM_MSB = ANG_Q - 1;

  // magnitude stage
  logic [W_OP-1:0] ax0_r, ay0_r, m0_r;
  cside_t          sd0_r;
  // group detect stage
  logic [W_OP-1:0] ax1_r, ay1_r;
  logic [NG-1:0]   gnz_r;
  logic [2:0]      gpos_r [NG];
  logic [NG-1:0]   gnz_nxt;
  logic [2:0]      gpos_nxt [NG];
  logic [NG*8-1:0] mpad;
  cside_t          sd1_r;
  // position stage
  logic [W_OP-1:0]  ax2_r, ay2_r;
  logic [W_POS-1:0] pos_r, pos_nxt;
  cside_t           sd2_r;
  // iterations
  logic signed [W_C-1:0] cx_r [CORDIC_STEPS+1];
  logic signed [W_C-1:0] cy_r [CORDIC_STEPS+1];
  logic signed [W_C-1:0] cz_r [CORDIC_STEPS+1];
  cside_t                sdi_r [CORDIC_STEPS+1];
  logic [W_OP-1:0]       sx, sy;
  // output
  logic signed [W_C-1:0] ang_nxt, ang_r;
  logic [CORDIC_LAT-1:0] vld_r;

  logic [W_OP-1:0] ax_in, ay_in;
  assign ax_in = op_x[W_OP-1] ? W_OP'(-op_x) : W_OP'(op_x);
  assign ay_in = op_y[W_OP-1] ? W_OP'(-op_y) : W_OP'(op_y);

  always_ff @(posedge clk) begin
    ax0_r      <= ax_in;
    ay0_r      <= ay_in;
    m0_r       <= (ax_in > ay_in) ? ax_in : ay_in;
    sd0_r.xneg <= op_x[W_OP-1];
    sd0_r.yneg <= op_y[W_OP-1];
    sd0_r.zero <= 1'b0;
  end

  // leading one: per byte first, then across bytes
  assign mpad = (NG*8)'(m0_r);
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gnz_nxt[g]  = |mpad[g*8 +: 8];
      gpos_nxt[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (mpad[g*8 + j]) gpos_nxt[g] = 3'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    ax1_r <= ax0_r;
    ay1_r <= ay0_r;
    gnz_r <= gnz_nxt;
    for (int g = 0; g < NG; g++) gpos_r[g] <= gpos_nxt[g];
    sd1_r <= sd0_r;
  end

  always_comb begin
    pos_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz_r[g]) pos_nxt = W_POS'(g * 8) + W_POS'(gpos_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    ax2_r      <= ax1_r;
    ay2_r      <= ay1_r;
    pos_r      <= pos_nxt;
    sd2_r.xneg <= sd1_r.xneg;
    sd2_r.yneg <= sd1_r.yneg;
    sd2_r.zero <= ~|gnz_r;
  end

  // bring the larger magnitude into [2^29, 2^30)
  always_comb begin
    if (pos_r >= W_POS'(NORM_MSB)) begin
      sx = ax2_r >> (pos_r - W_POS'(NORM_MSB));
      sy = ay2_r >> (pos_r - W_POS'(NORM_MSB));
    end else begin
      sx = ax2_r << (W_POS'(NORM_MSB) - pos_r);
      sy = ay2_r << (W_POS'(NORM_MSB) - pos_r);
    end
  end

  always_ff @(posedge clk) begin
    cx_r[0]  <= W_C'(sx[ANG_Q-1:0]);
    cy_r[0]  <= W_C'(sy[ANG_Q-1:0]);
    cz_r[0]  <= '0;
    sdi_r[0] <= sd2_r;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
    localparam logic signed [W_C-1:0] A = atan_q30(i);
    always_ff @(posedge clk) begin
      if (!cy_r[i][W_C-1]) begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + A;
      end else begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - A;
      end
      sdi_r[i+1] <= sdi_r[i];
    end
  end

  always_comb begin
    ang_nxt = cz_r[CORDIC_STEPS];
    if (ang_nxt[W_C-1]) begin
      ang_nxt = '0;
    end else if (ang_nxt > HALF_PI_Q30) begin
      ang_nxt = HALF_PI_Q30;
    end
    if (sdi_r[CORDIC_STEPS].xneg) ang_nxt = PI_Q30 - ang_nxt;
    if (sdi_r[CORDIC_STEPS].yneg) ang_nxt = -ang_nxt;
    if (sdi_r[CORDIC_STEPS].zero) ang_nxt = '0;
  end

  always_ff @(posedge clk) begin
    ang_r <= ang_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CORDIC_LAT-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[CORDIC_LAT-1];
  assign angle   = ang_r;

endmodule

// File: rtl/gaze_point_to_joint_angles.sv
// ----------------------------------------------------------------------------
// gaze_point_to_joint_angles
// Fixation point in the neck frame to neck pan/tilt and eye vergence angles.
// ----------------------------------------------------------------------------
// path: the word runs through two multiply and square root chains,
//   then a 35-stage cordic, before out_valid is raised
// throughput: one word per cycle, busy stays low; results cannot be stalled
// reset: rst_n low clears all valid bits and loads the offset registers
//   with 0, 0 and 3277
module gaze_point_to_joint_angles (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [gpja_pkg::W_IN-1:0]   in_point_x,
  input  logic signed [gpja_pkg::W_IN-1:0]   in_point_y,
  input  logic signed [gpja_pkg::W_IN-1:0]   in_point_z,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic signed [gpja_pkg::W_ANG-1:0]  out_pan_angle,
  output logic signed [gpja_pkg::W_ANG-1:0]  out_tilt_angle,
  output logic signed [gpja_pkg::W_ANG-1:0]  out_left_eye_angle,
  output logic signed [gpja_pkg::W_ANG-1:0]  out_right_eye_angle,
  input  logic                               cfg_we,
  input  logic [gpja_pkg::W_CFG_IDX-1:0]     cfg_index,
  input  logic [gpja_pkg::W_OFF-1:0]         cfg_data
);
  import gpja_pkg::*;

  localparam int DA      = MUL_LAT + SQRT_LAT;
  localparam int TB_OFF  = 2 * DA + 3;
  localparam int VS_DLY  = TB_OFF - SQRT_LAT - 1;
  localparam int ST_DLY  = TB_OFF + CORDIC_LAT;
  localparam int OUT_LAT = TB_OFF + CORDIC_LAT + 7;

  typedef struct packed {
    logic [W_N2-1:0]         n2;
    logic signed [W_YYO-1:0] yyo;
  } dla_t;

  typedef struct packed {
    logic signed [W_IN-1:0] x;
    logic signed [W_IN-1:0] z;
  } dlp_t;

  typedef struct packed {
    status_t st;
    logic    ybelow;
  } dls_t;

  // configuration
  logic signed [W_OFF-1:0] lat_r, vert_r;
  logic [W_HB-1:0]         hb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r  <= '0;
      vert_r <= '0;
      hb_r   <= HB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LATERAL:  lat_r  <= cfg_data;
        CFG_VERTICAL: vert_r <= cfg_data;
        CFG_HALFBASE: hb_r   <= cfg_data[W_HB-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // front stages: capture, squares, sums, status
  logic                       v0_r, v1_r, v2_r, v3_r;
  logic signed [W_IN-1:0]     x0_r, y0_r, z0_r, x1_r, z1_r, x2_r, z2_r, x3_r, z3_r;
  logic signed [2*W_IN-1:0]   xx_r, yy_r, zz_r;
  logic signed [W_YYO-1:0]    yyo1_r, yyo2_r, yyo3_r;
  logic signed [2*W_OFF-1:0]  yo2_1_r, yo2_2_r;
  logic signed [W_IN:0]       ysum;
  logic                       yb1_r, yb2_r, yb3_r;
  logic [W_N2-1:0]            r2_2_r, n2_2_r, r2_3_r, n2_3_r, m3_r;
  status_t                    st3_r;

  assign ysum = (W_IN+1)'(y0_r) + (W_IN+1)'(lat_r);

  always_ff @(posedge clk) begin
    x0_r    <= in_point_x;
    y0_r    <= in_point_y;
    z0_r    <= in_point_z;
    xx_r    <= x0_r * x0_r;
    yy_r    <= y0_r * y0_r;
    zz_r    <= z0_r * z0_r;
    yyo1_r  <= y0_r * lat_r;
    yo2_1_r <= lat_r * lat_r;
    yb1_r   <= ysum[W_IN];
    x1_r    <= x0_r;
    z1_r    <= z0_r;
    r2_2_r  <= W_N2'(xx_r) + W_N2'(zz_r);
    n2_2_r  <= W_N2'(xx_r) + W_N2'(zz_r) + W_N2'(yy_r);
    yyo2_r  <= yyo1_r;
    yo2_2_r <= yo2_1_r;
    yb2_r   <= yb1_r;
    x2_r    <= x1_r;
    z2_r    <= z1_r;
    r2_3_r  <= r2_2_r;
    n2_3_r  <= n2_2_r;
    m3_r    <= n2_2_r - W_N2'(yo2_2_r);
    yyo3_r  <= yyo2_r;
    yb3_r   <= yb2_r;
    x3_r    <= x2_r;
    z3_r    <= z2_r;
    if (n2_2_r == '0) begin
      st3_r <= ST_ZERO;
    end else if (n2_2_r < W_N2'(yo2_2_r)) begin
      st3_r <= ST_INSIDE;
    end else begin
      st3_r <= ST_OK;
    end
  end

  // sqrt((x^2+z^2)*(|p|^2-yo^2))
  logic                   mula_v, sqa_v;
  logic [2*W_MUL-1:0]     mula_p;
  logic [W_SQ_OUT-1:0]    sqa;

  gpja_mul u_mul_a (
    .clk(clk), .rst_n(rst_n), .in_vld(v3_r),
    .a(W_MUL'(r2_3_r)), .b(W_MUL'(m3_r)),
    .out_vld(mula_v), .prod(mula_p)
  );

  gpja_isqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .in_vld(mula_v), .val(mula_p),
    .out_vld(sqa_v), .root(sqa)
  );

  // sqrt(|p|^2-yo^2) for the vergence
  logic                   sqc_v;
  logic [W_SQ_OUT-1:0]    sqc;
  logic signed [W_OP-1:0] vsum_r;

  gpja_isqrt u_sqrt_c (
    .clk(clk), .rst_n(rst_n), .in_vld(v3_r), .val(W_SQ_IN'(m3_r)),
    .out_vld(sqc_v), .root(sqc)
  );

  always_ff @(posedge clk) begin
    if (sqc_v) vsum_r <= W_OP'(signed'({1'b0, sqc})) + W_OP'(vert_r);
  end

  // shift lines keeping side data in step with the units
  dla_t                   dla_r [DA];
  logic signed [W_OP-1:0] dlb_r [DA];
  dlp_t                   dlp_r [TB_OFF];
  logic signed [W_OP-1:0] dlv_r [VS_DLY];
  dls_t                   dls_r [ST_DLY];
  logic signed [W_OP-1:0] aux4_r, aux5_r, aux6_r, auxc;
  logic [W_N2-1:0]        n2_4_r, n2_5_r;
  logic signed [W_OP-1:0] n2s5;
  logic                   v4_r, v5_r, v6_r;
  logic [W_MUL-1:0]       dif6_r, sum6_r;

  always_ff @(posedge clk) begin
    dla_r[0] <= {n2_3_r, yyo3_r};
    for (int k = 1; k < DA; k++) dla_r[k] <= dla_r[k-1];
    dlb_r[0] <= aux6_r;
    for (int k = 1; k < DA; k++) dlb_r[k] <= dlb_r[k-1];
    dlp_r[0] <= {x3_r, z3_r};
    for (int k = 1; k < TB_OFF; k++) dlp_r[k] <= dlp_r[k-1];
    dlv_r[0] <= vsum_r;
    for (int k = 1; k < VS_DLY; k++) dlv_r[k] <= dlv_r[k-1];
    dls_r[0] <= {st3_r, yb3_r};
    for (int k = 1; k < ST_DLY; k++) dls_r[k] <= dls_r[k-1];
  end

  // aux = sqrt(..) - y*yo, clamped to [-|p|^2, |p|^2]
  assign n2s5 = W_OP'(signed'({1'b0, n2_4_r}));

  always_comb begin
    auxc = aux4_r;
    if (aux4_r > n2s5) begin
      auxc = n2s5;
    end else if (aux4_r < -n2s5) begin
      auxc = -n2s5;
    end
  end

  always_ff @(posedge clk) begin
    aux4_r <= W_OP'(signed'({1'b0, sqa})) - W_OP'(dla_r[DA-1].yyo);
    n2_4_r <= dla_r[DA-1].n2;
    aux5_r <= auxc;
    n2_5_r <= n2_4_r;
    aux6_r <= aux5_r;
    dif6_r <= W_MUL'(W_OP'(signed'({1'b0, n2_5_r})) - aux5_r);
    sum6_r <= W_MUL'(W_OP'(signed'({1'b0, n2_5_r})) + aux5_r);
  end

  // acos numerator: sqrt((n2-aux)*(n2+aux))
  logic                mulb_v, sqb_v;
  logic [2*W_MUL-1:0]  mulb_p;
  logic [W_SQ_OUT-1:0] sqb;

  gpja_mul u_mul_b (
    .clk(clk), .rst_n(rst_n), .in_vld(v6_r), .a(dif6_r), .b(sum6_r),
    .out_vld(mulb_v), .prod(mulb_p)
  );

  gpja_isqrt u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .in_vld(mulb_v), .val(mulb_p),
    .out_vld(sqb_v), .root(sqb)
  );

  // three atan2 units start together
  logic                  pan_v, tilt_v, verg_v;
  logic signed [W_C-1:0] pan_a, acs_a, verg_a;

  gpja_cordic u_cordic_pan (
    .clk(clk), .rst_n(rst_n), .in_vld(sqb_v),
    .op_y(W_OP'(dlp_r[TB_OFF-1].x)), .op_x(W_OP'(dlp_r[TB_OFF-1].z)),
    .out_vld(pan_v), .angle(pan_a)
  );

  gpja_cordic u_cordic_tilt (
    .clk(clk), .rst_n(rst_n), .in_vld(sqb_v),
    .op_y(W_OP'(signed'({1'b0, sqb}))), .op_x(dlb_r[DA-1]),
    .out_vld(tilt_v), .angle(acs_a)
  );

  gpja_cordic u_cordic_verg (
    .clk(clk), .rst_n(rst_n), .in_vld(sqb_v),
    .op_y(dlv_r[VS_DLY-1]), .op_x(W_OP'(signed'({1'b0, hb_r}))),
    .out_vld(verg_v), .angle(verg_a)
  );

  // back end: sign, rounding, output words
  logic                   f1_v_r, f2_v_r, f3_v_r;
  logic signed [W_C-1:0]  pan1_r, tilt1_r, half1_r;
  status_t                st1_r, st2_r, st3o_r;
  logic [W_ANG-1:0]       pan2_r, tilt2_r, half2_r;
  logic [W_ANG-1:0]       pan3_r, tilt3_r, left3_r, right3_r;

  always_ff @(posedge clk) begin
    pan1_r  <= pan_a;
    tilt1_r <= dls_r[ST_DLY-1].ybelow ? acs_a : -acs_a;
    half1_r <= HALF_PI_Q30 - verg_a;
    st1_r   <= dls_r[ST_DLY-1].st;
    pan2_r  <= to_out(pan1_r);
    tilt2_r <= to_out(tilt1_r);
    half2_r <= to_out(half1_r);
    st2_r   <= st1_r;
    st3o_r  <= st2_r;
    if (st2_r == ST_OK) begin
      pan3_r   <= pan2_r;
      tilt3_r  <= tilt2_r;
      left3_r  <= half2_r;
      right3_r <= ~half2_r + W_ANG'(1);
    end else begin
      pan3_r   <= '0;
      tilt3_r  <= '0;
      left3_r  <= '0;
      right3_r <= '0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      v6_r   <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else begin
      v0_r   <= start & ~busy;
      v1_r   <= v0_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= sqa_v;
      v5_r   <= v4_r;
      v6_r   <= v5_r;
      f1_v_r <= pan_v & tilt_v & verg_v;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  assign out_valid           = f3_v_r;
  assign out_status          = st3o_r;
  assign out_pan_angle       = pan3_r;
  assign out_tilt_angle      = tilt3_r;
  assign out_left_eye_angle  = left3_r;
  assign out_right_eye_angle = right3_r;

`ifndef ASSERT_OFF
  a_cordic_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (pan_v == tilt_v) && (tilt_v == verg_v))
    else $error("atan2 units out of step");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##OUT_LAT out_valid)
    else $error("result word missing at fixed latency");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      (out_pan_angle == '0) && (out_tilt_angle == '0) &&
      (out_left_eye_angle == '0) && (out_right_eye_angle == '0))
    else $error("nonzero angle with fault status");

  a_eyes_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_right_eye_angle == W_ANG'(-out_left_eye_angle)))
    else $error("eye angles not mirrored");
`endif

endmodule

// File: verif/gaze_point_to_joint_angles_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaze_point_to_joint_angles_tb
// Drives fixation points through the joint angle pipeline under a series of
// offset and baseline settings. A typed row or a bit exact predictor gives
// the expected word per accepted point; out_valid words are checked in order.
// ----------------------------------------------------------------------------
module gaze_point_to_joint_angles_tb;
  import gpja_pkg::*;

  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint PI_VAL  = 64'sd3373259426;

  typedef struct {
    status_t      status;
    logic [18:0]  pan;
    logic [18:0]  tilt;
    logic [18:0]  left_eye;
    logic [18:0]  right_eye;
  } angles_t;

  typedef struct {
    int      lat;
    int      px;
    int      py;
    int      pz;
    bit      typed;
    status_t st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [W_IN-1:0] in_point_x = '0;
  logic signed [W_IN-1:0] in_point_y = '0;
  logic signed [W_IN-1:0] in_point_z = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [W_ANG-1:0] out_pan_angle, out_tilt_angle;
  logic signed [W_ANG-1:0] out_left_eye_angle, out_right_eye_angle;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_LATERAL;
  logic [W_OFF-1:0] cfg_data = '0;

  // shadow registers
  logic [17:0] sh_lateral = '0;
  logic [17:0] sh_vertical = '0;
  logic [16:0] sh_halfbase = 17'd3277;

  angles_t angle_q[$];
  angles_t typed_word;
  bit      typed_pending = 1'b0;
  int      n_taken = 0;
  int      n_err = 0;

  always #4 clk = ~clk;

  gaze_point_to_joint_angles u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_status(out_status),
    .out_pan_angle(out_pan_angle), .out_tilt_angle(out_tilt_angle),
    .out_left_eye_angle(out_left_eye_angle), .out_right_eye_angle(out_right_eye_angle),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint unsigned int_sqrt(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] t;
    logic [127:0] tt;
    r = '0;
    for (int b = 44; b >= 0; b--) begin
      t = r | (64'd1 << b);
      tt = {64'd0, t} * {64'd0, t};
      if (tt <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint cordic_atan2(longint yv, longint xv);
    longint unsigned ax, ay, mx;
    longint cx, cy, zacc, a, dx, dy;
    ax = (xv < 0) ? -xv : xv;
    ay = (yv < 0) ? -yv : yv;
    mx = (ax > ay) ? ax : ay;
    zacc = 0;
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      ax >>= 1; ay >>= 1; mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      ax <<= 1; ay <<= 1; mx <<= 1;
    end
    cx = ax;
    cy = ay;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      a = atan_q30(i);
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; zacc += a;
      end else begin
        cx -= dx; cy += dy; zacc -= a;
      end
    end
    if (zacc < 0) zacc = 0;
    if (zacc > HALF_PI) zacc = HALF_PI;
    if (xv < 0) zacc = PI_VAL - zacc;
    if (yv < 0) zacc = -zacc;
    return zacc;
  endfunction

  function automatic longint q30_to_units(longint a);
    longint half;
    half = longint'(1) << (ANG_SHIFT - 1);
    if (a >= 0) return (a + half) >>> ANG_SHIFT;
    return -(((-a) + half) >>> ANG_SHIFT);
  endfunction

  function automatic angles_t predict_angles(longint x, longint y, longint z);
    angles_t w;
    longint yo, zo, r2, n2, yo2, m, aux, acs, tilt, pan, rad, theta, half;
    logic [127:0] prod;
    yo = longint'($signed(sh_lateral));
    zo = longint'($signed(sh_vertical));
    r2 = x * x + z * z;
    n2 = r2 + y * y;
    yo2 = yo * yo;
    w = '{ST_OK, '0, '0, '0, '0};
    if (n2 == 0) begin
      w.status = ST_ZERO;
      return w;
    end
    if (n2 < yo2) begin
      w.status = ST_INSIDE;
      return w;
    end
    m = n2 - yo2;
    prod = {64'd0, r2} * {64'd0, m};
    aux = longint'(int_sqrt(prod)) - y * yo;
    if (aux > n2) aux = n2;
    if (aux < -n2) aux = -n2;
    prod = {64'd0, n2 - aux} * {64'd0, n2 + aux};
    acs = cordic_atan2(longint'(int_sqrt(prod)), aux);
    tilt = (y < -yo) ? acs : -acs;
    pan = cordic_atan2(x, z);
    rad = int_sqrt({64'd0, m});
    theta = cordic_atan2(rad + zo, longint'(sh_halfbase));
    half = q30_to_units(HALF_PI - theta);
    w.pan = W_ANG'(q30_to_units(pan));
    w.tilt = W_ANG'(q30_to_units(tilt));
    w.left_eye = W_ANG'(half);
    w.right_eye = W_ANG'(-half);
    return w;
  endfunction

  // acceptance, shadow config and output check all on the rising edge
  always @(posedge clk) begin
    angles_t e;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_LATERAL:  sh_lateral  = cfg_data;
        CFG_VERTICAL: sh_vertical = cfg_data;
        CFG_HALFBASE: sh_halfbase = cfg_data[16:0];
        default: ;
      endcase
    end
    if (rst_n && start && !busy) begin
      if (typed_pending) angle_q.push_back(typed_word);
      else angle_q.push_back(predict_angles(in_point_x, in_point_y, in_point_z));
      n_taken++;
    end
    if (rst_n && out_valid) begin
      if (angle_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word: status %0d", out_status);
      end else begin
        e = angle_q.pop_front();
        if (out_status !== e.status || out_pan_angle !== e.pan ||
            out_tilt_angle !== e.tilt || out_left_eye_angle !== e.left_eye ||
            out_right_eye_angle !== e.right_eye) begin
          n_err++;
          if (n_err <= 10)
            $display({"mismatch: exp st %0d pan %h tilt %h l %h r %h,",
                      " got st %0d pan %h tilt %h l %h r %h"},
                     e.status, e.pan, e.tilt, e.left_eye, e.right_eye, out_status,
                     out_pan_angle, out_tilt_angle, out_left_eye_angle,
                     out_right_eye_angle);
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_point(int px, int py, int pz, bit typed, status_t st);
    int seen;
    seen = n_taken;
    start = 1'b1;
    in_point_x = W_IN'(px);
    in_point_y = W_IN'(py);
    in_point_z = W_IN'(pz);
    typed_pending = typed;
    typed_word = '{st, '0, '0, '0, '0};
    do @(negedge clk); while (n_taken == seen);
  endtask

  task automatic drain_idle();
    start = 1'b0;
    while (angle_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = W_OFF'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(int lat, int vert, int hb);
    drain_idle();
    write_reg(CFG_LATERAL, lat);
    write_reg(CFG_VERTICAL, vert);
    write_reg(CFG_HALFBASE, hb);
  endtask

  function automatic int rand_range(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic random_point(output int px, output int py, output int pz);
    int mode, lat;
    mode = $urandom_range(99);
    lat = $signed(sh_lateral);
    if (mode < 55) begin
      px = rand_range(-524288, 524288);
      py = rand_range(-524288, 524288);
      pz = rand_range(-524288, 524288);
    end else if (mode < 75) begin
      px = rand_range(-3000, 3000);
      py = rand_range(-3000, 3000);
      pz = rand_range(-3000, 3000);
    end else if (mode < 90) begin
      // around the offset radius, both inside and just outside
      px = rand_range(-300, 300);
      pz = rand_range(-300, 300);
      py = ($urandom_range(1) ? lat : -lat) + rand_range(-400, 400);
    end else if (mode < 94) begin
      px = 0; py = 0; pz = 0;
    end else begin
      px = $urandom_range(1) ? 524288 : -524288;
      py = $urandom_range(1) ? 0 : -524288;
      pz = $urandom_range(1) ? 524288 : 0;
    end
  endtask

  dir_row_t dir_rows[] = '{
    '{0, 0, 0, 0, 1'b1, ST_ZERO},
    '{0, 524288, 524288, 524288, 1'b0, ST_OK},
    '{0, -524288, -524288, -524288, 1'b0, ST_OK},
    '{0, 0, 0, -524288, 1'b0, ST_OK},
    '{0, 524288, 0, 0, 1'b0, ST_OK},
    '{0, -1, 0, 0, 1'b0, ST_OK},
    '{0, 0, 1, 0, 1'b0, ST_OK},
    '{0, 0, -1, 0, 1'b0, ST_OK},
    '{0, 1, 1, 1, 1'b0, ST_OK},
    '{0, -524288, 524288, 0, 1'b0, ST_OK},
    '{65536, 1, 0, 0, 1'b1, ST_INSIDE},
    '{65536, 0, -65535, 0, 1'b1, ST_INSIDE},
    '{65536, 100, 100, 100, 1'b1, ST_INSIDE},
    '{65536, 0, 0, 0, 1'b1, ST_ZERO},
    '{65536, 0, 65536, 0, 1'b0, ST_OK},
    '{65536, 0, -65536, 0, 1'b0, ST_OK},
    '{65536, 0, -70000, 5, 1'b0, ST_OK},
    '{65536, 524288, -524288, 524288, 1'b0, ST_OK}
  };

  initial begin
    int cur_lat, px, py, pz, burst, gap;
    int phase_lat[6];
    int phase_vert[6];
    int phase_hb[6];
    phase_lat  = '{-65536, 65536, 0, 1234, -400, 30000};
    phase_vert = '{-65536, 65536, 0, -777, 40000, 0};
    phase_hb   = '{1, 65536, 3277, 65535, 12, 500};
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    cur_lat = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].lat != cur_lat) begin
        cur_lat = dir_rows[i].lat;
        set_config(cur_lat, 0, 3277);
      end
      send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz,
                 dir_rows[i].typed, dir_rows[i].st);
    end
    for (int p = 0; p < 6; p++) begin
      set_config(phase_lat[p], phase_vert[p], phase_hb[p]);
      for (int k = 0; k < 200;) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && k < 200; b++, k++) begin
          random_point(px, py, pz);
          send_point(px, py, pz, 1'b0, ST_OK);
        end
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          start = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    drain_idle();
    repeat (200) @(negedge clk);
    if (n_err == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
